[design/isometric_depth_order_sorter_assert.svh]
// assertion macros for the depth order sorter
`ifndef ISOMETRIC_DEPTH_ORDER_SORTER_ASSERT_SVH
`define ISOMETRIC_DEPTH_ORDER_SORTER_ASSERT_SVH
// property that must hold outside reset
`define IDOS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property that must hold at every edge
`define IDOS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[design/idos_pkg.sv]
// types, constants and helpers shared by the depth order sorter
package idos_pkg;
    localparam int StaticSlots  = 32;
    localparam int DynamicSlots = 16;
    localparam int WorkSlots    = 48;
    localparam int SAW = $clog2(StaticSlots);
    localparam int DAW = $clog2(DynamicSlots);
    localparam int WAW = $clog2(WorkSlots);
    localparam int SCW = $clog2(StaticSlots + 1);
    localparam int DCW = $clog2(DynamicSlots + 1);
    localparam int WCW = $clog2(WorkSlots + 1);

    typedef enum logic [2:0] {
        CMD_INS_STATIC = 3'd0,
        CMD_INS_DYN    = 3'd1,
        CMD_REM_STATIC = 3'd2,
        CMD_REM_DYN    = 3'd3,
        CMD_ORDER      = 3'd4
    } t_cmd;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_UNCHANGED = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic [7:0]         item_id;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_id;
        logic [5:0] rank;
        logic [1:0] status;
        logic       is_entry;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [7:0]         id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_box;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0] op;
        t_box       box;
    } t_job;

    localparam int JobW = $bits(t_job);

    function automatic logic [1:0] axis_cmp(input logic signed [15:0] e0,
                                            input logic [14:0] elen,
                                            input logic signed [15:0] n0,
                                            input logic [14:0] nlen);
        logic signed [17:0] ee;
        logic signed [17:0] ne;
        begin
            ee = 18'(e0) + 18'($signed({3'b000, elen}));
            ne = 18'(n0) + 18'($signed({3'b000, nlen}));
            if (18'(n0) >= ee)      axis_cmp = 2'b01;
            else if (ne <= 18'(e0)) axis_cmp = 2'b11;
            else                    axis_cmp = 2'b00;
        end
    endfunction

    // side of new box against entry: signed sum of the two axis results
    function automatic logic [2:0] side_of(input t_box e, input t_box n);
        logic [1:0] a;
        logic [1:0] b;
        begin
            a = axis_cmp(e.x, e.w, n.x, n.w);
            b = axis_cmp(e.y, e.h, n.y, n.h);
            side_of = 3'($signed(a)) + 3'($signed(b));
        end
    endfunction
endpackage

[design/idos_front.sv]
// front: accepts command words, drops unknown codes, fills the job queue
module idos_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  idos_pkg::t_in_word      i_word,
    input  logic                    i_push,
    output logic                    o_full,
    output idos_pkg::t_job          o_job,
    output logic                    o_job_valid,
    input  logic                    i_job_take
);
    localparam int Depth = 2;
    logic [idos_pkg::JobW-1:0] r_mem [Depth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_acc;
    logic       w_known;
    idos_pkg::t_job w_job;

    assign o_full      = (r_cnt == 2'(Depth));
    assign w_acc       = i_push && !o_full;
    assign w_known     = (i_word.command <= 3'(idos_pkg::CMD_ORDER));
    assign w_job.op    = i_word.command;
    assign w_job.box   = '{id: i_word.item_id, x: i_word.rect_x, y: i_word.rect_y,
                           w: i_word.rect_w, h: i_word.rect_h};
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = idos_pkg::t_job'(r_mem[r_rp]);

    always_ff @(posedge i_clk) begin
        if (w_acc && w_known) begin
            r_mem[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc && w_known) r_wp <= ~r_wp;
            if (i_job_take && o_job_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_acc && w_known) - 2'(i_job_take && o_job_valid);
        end
    end

    `include "isometric_depth_order_sorter_assert.svh"
    `IDOS_ASSERT(a_no_overflow, i_clk, i_rst_n, (r_cnt <= 2'(Depth)), "job queue overflow")
    `IDOS_ASSERT(a_cnt_track, i_clk, i_rst_n, (o_full |-> !(w_acc)), "accept while full")
    `IDOS_ASSERT(a_unknown_drop, i_clk, i_rst_n, ((w_acc && !w_known && !(i_job_take && o_job_valid)) |=> $stable(r_cnt)), "unknown command queued")
endmodule

[design/idos_back.sv]
// back: list store, placement walk and result sequencer
module idos_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  idos_pkg::t_job        i_job,
    input  logic                  i_job_valid,
    output logic                  o_job_take,
    output idos_pkg::t_out_word   o_word,
    output logic                  o_empty,
    input  logic                  i_pop
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_LOAD, S_TAIL, S_SPLIT, S_MERGE, S_COPYBACK,
        S_REMOVE, S_SHIFT, S_NEXTDYN, S_EMIT, S_STATUS
    } t_state;

    // stores: statics, dynamics, work list and high side scratch
    idos_pkg::t_box r_st [idos_pkg::StaticSlots];
    idos_pkg::t_box r_dy [idos_pkg::DynamicSlots];
    idos_pkg::t_box r_wk [idos_pkg::WorkSlots];
    idos_pkg::t_box r_hi [idos_pkg::WorkSlots];

    t_state r_state;
    logic [idos_pkg::SCW-1:0] r_scount;
    logic [idos_pkg::DCW-1:0] r_dcount;
    logic                     r_dirty;
    logic [idos_pkg::WCW-1:0] r_n;     // work list length
    logic [idos_pkg::WCW-1:0] r_i;     // walk index
    logic [idos_pkg::WCW-1:0] r_nl;
    logic [idos_pkg::WCW-1:0] r_nh;
    logic [idos_pkg::WCW-1:0] r_j;
    logic [idos_pkg::DCW-1:0] r_d;     // dynamic index during order
    logic                     r_seen;
    logic [2:0]               r_op;
    idos_pkg::t_box           r_nb;
    idos_pkg::t_box           r_rd;    // registered work entry
    logic [1:0]               r_stat;
    logic                     r_ovalid;
    idos_pkg::t_out_word      r_out;
    logic                     r_hold;

    logic w_slot_free;
    logic w_out_load;
    logic [2:0] w_side;

    assign o_empty     = !r_ovalid;
    assign o_word      = r_out;
    assign w_slot_free = !r_ovalid || i_pop;
    // a new word enters the output register this cycle
    assign w_out_load  = w_slot_free && ((r_state == S_STATUS)
                                         || ((r_state == S_EMIT) && (r_n != '0)));
    assign o_job_take  = (r_state == S_IDLE) && i_job_valid;
    assign w_side      = idos_pkg::side_of(r_rd, r_nb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scount <= '0;
            r_dcount <= '0;
            r_dirty  <= 1'b1;
            r_ovalid <= 1'b0;
            r_hold   <= 1'b0;
        end else begin
            if (i_pop && r_ovalid && !w_out_load) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_op    <= i_job.op;
                        r_nb    <= i_job.box;
                        r_i     <= '0;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_stat <= idos_pkg::ST_OK;
                    case (idos_pkg::t_cmd'(r_op))
                        idos_pkg::CMD_INS_STATIC: begin
                            if (r_scount >= idos_pkg::SCW'(idos_pkg::StaticSlots)) begin
                                r_stat  <= idos_pkg::ST_FULL;
                                r_state <= S_STATUS;
                            end else begin
                                r_dirty <= 1'b1;
                                r_state <= S_LOAD;
                            end
                        end
                        idos_pkg::CMD_INS_DYN: begin
                            if (r_dcount >= idos_pkg::DCW'(idos_pkg::DynamicSlots)) begin
                                r_stat <= idos_pkg::ST_FULL;
                            end else begin
                                r_dy[r_dcount[idos_pkg::DAW-1:0]] <= r_nb;
                                r_dcount <= r_dcount + 1'b1;
                            end
                            r_state <= S_STATUS;
                        end
                        idos_pkg::CMD_REM_STATIC, idos_pkg::CMD_REM_DYN: begin
                            r_state <= S_REMOVE;
                        end
                        idos_pkg::CMD_ORDER: begin
                            if (r_dcount != '0) begin
                                r_d <= '0;
                                r_state <= S_LOAD;
                            end else if (r_dirty) begin
                                r_dirty <= 1'b0;
                                r_state <= S_LOAD;
                            end else begin
                                r_stat  <= idos_pkg::ST_UNCHANGED;
                                r_state <= S_STATUS;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                // copy statics into the work list
                S_LOAD: begin
                    if (r_i < idos_pkg::WCW'(r_scount)) begin
                        r_wk[r_i[idos_pkg::WAW-1:0]] <= r_st[r_i[idos_pkg::SAW-1:0]];
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_n <= r_i;
                        r_i <= '0;
                        if (r_op == 3'(idos_pkg::CMD_INS_STATIC)) begin
                            r_state <= S_TAIL;
                        end else if (r_dcount != '0) begin
                            r_state <= S_NEXTDYN;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_NEXTDYN: begin
                    if (r_d == r_dcount) begin
                        r_i <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_d <= r_d + 1'b1;
                        if (r_n < idos_pkg::WCW'(idos_pkg::WorkSlots)) begin
                            r_nb    <= r_dy[r_d[idos_pkg::DAW-1:0]];
                            r_state <= S_TAIL;
                        end
                    end
                end
                // empty list takes the box, else read the last entry, then decide append or split
                S_TAIL: begin
                    if (r_n == '0) begin
                        r_wk[0] <= r_nb;
                        r_n <= idos_pkg::WCW'(1);
                        r_state <= (r_op == 3'(idos_pkg::CMD_INS_STATIC)) ? S_COPYBACK
                                                                         : S_NEXTDYN;
                        r_i <= '0;
                    end else if (!r_hold) begin
                        r_rd   <= r_wk[r_i[idos_pkg::WAW-1:0] + idos_pkg::WAW'(r_n - 1'b1)];
                        r_hold <= 1'b1;
                    end else begin
                        r_hold <= 1'b0;
                        if (w_side[2]) begin
                            r_wk[r_n[idos_pkg::WAW-1:0]] <= r_nb;
                            r_n <= r_n + 1'b1;
                            r_i <= '0;
                            r_state <= (r_op == 3'(idos_pkg::CMD_INS_STATIC)) ? S_COPYBACK
                                                                             : S_NEXTDYN;
                        end else begin
                            r_i <= '0;
                            r_nl <= '0;
                            r_nh <= '0;
                            r_seen <= 1'b0;
                            r_state <= S_SPLIT;
                        end
                    end
                end
                // per entry: read, then classify and route
                S_SPLIT: begin
                    if (!r_hold) begin
                        if (r_i == r_n) begin
                            r_wk[r_nl[idos_pkg::WAW-1:0]] <= r_nb;
                            r_nl <= r_nl + 1'b1;
                            r_j  <= '0;
                            r_state <= S_MERGE;
                        end else begin
                            r_rd   <= r_wk[r_i[idos_pkg::WAW-1:0]];
                            r_hold <= 1'b1;
                        end
                    end else begin
                        r_hold <= 1'b0;
                        r_i    <= r_i + 1'b1;
                        if (!w_side[2] && (w_side != 3'd0 || r_seen)) begin
                            r_hi[r_nh[idos_pkg::WAW-1:0]] <= r_rd;
                            r_nh <= r_nh + 1'b1;
                            if (w_side != 3'd0) r_seen <= 1'b1;
                        end else begin
                            r_wk[r_nl[idos_pkg::WAW-1:0]] <= r_rd;
                            r_nl <= r_nl + 1'b1;
                        end
                    end
                end
                S_MERGE: begin
                    if (r_j == r_nh) begin
                        r_n <= r_nl;
                        r_i <= '0;
                        r_state <= (r_op == 3'(idos_pkg::CMD_INS_STATIC)) ? S_COPYBACK
                                                                         : S_NEXTDYN;
                    end else begin
                        r_wk[r_nl[idos_pkg::WAW-1:0]] <= r_hi[r_j[idos_pkg::WAW-1:0]];
                        r_nl <= r_nl + 1'b1;
                        r_j  <= r_j + 1'b1;
                    end
                end
                S_COPYBACK: begin
                    if (r_i == r_n) begin
                        r_scount <= idos_pkg::SCW'(r_n);
                        r_state  <= S_STATUS;
                    end else begin
                        r_st[r_i[idos_pkg::SAW-1:0]] <= r_wk[r_i[idos_pkg::WAW-1:0]];
                        r_i <= r_i + 1'b1;
                    end
                end
                // find first match, then shift the rest down
                S_REMOVE: begin
                    if (r_op == 3'(idos_pkg::CMD_REM_STATIC)
                        ? (r_i == idos_pkg::WCW'(r_scount))
                        : (r_i == idos_pkg::WCW'(r_dcount))) begin
                        r_stat  <= idos_pkg::ST_NOT_FOUND;
                        r_state <= S_STATUS;
                    end else if ((r_op == 3'(idos_pkg::CMD_REM_STATIC)
                                  ? r_st[r_i[idos_pkg::SAW-1:0]].id
                                  : r_dy[r_i[idos_pkg::DAW-1:0]].id) == r_nb.id) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SHIFT;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SHIFT: begin
                    if (r_op == 3'(idos_pkg::CMD_REM_STATIC)) begin
                        if (r_i == idos_pkg::WCW'(r_scount)) begin
                            r_scount <= r_scount - 1'b1;
                            r_state  <= S_STATUS;
                        end else begin
                            r_st[r_i[idos_pkg::SAW-1:0] - 1'b1] <= r_st[r_i[idos_pkg::SAW-1:0]];
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        if (r_i == idos_pkg::WCW'(r_dcount)) begin
                            r_dcount <= r_dcount - 1'b1;
                            r_state  <= S_STATUS;
                        end else begin
                            r_dy[r_i[idos_pkg::DAW-1:0] - 1'b1] <= r_dy[r_i[idos_pkg::DAW-1:0]];
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (r_n == '0) begin
                        r_stat  <= idos_pkg::ST_OK;
                        r_state <= S_STATUS;
                    end else if (w_slot_free) begin
                        r_out.out_id   <= r_wk[r_i[idos_pkg::WAW-1:0]].id;
                        r_out.rank     <= 6'(r_i + 1'b1);
                        r_out.status   <= idos_pkg::ST_OK;
                        r_out.is_entry <= 1'b1;
                        r_out.last     <= (r_i + 1'b1 == r_n);
                        r_ovalid       <= 1'b1;
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 == r_n) r_state <= S_IDLE;
                    end
                end
                S_STATUS: begin
                    if (w_slot_free) begin
                        r_out    <= '{out_id: 8'd0, rank: 6'd0, status: r_stat,
                                      is_entry: 1'b0, last: 1'b1};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "isometric_depth_order_sorter_assert.svh"
    `IDOS_ASSERT(a_scount_max, i_clk, i_rst_n, (r_scount <= idos_pkg::SCW'(idos_pkg::StaticSlots)), "static count overflow")
    `IDOS_ASSERT(a_dcount_max, i_clk, i_rst_n, (r_dcount <= idos_pkg::DCW'(idos_pkg::DynamicSlots)), "dynamic count overflow")
    `IDOS_ASSERT(a_work_max, i_clk, i_rst_n, (r_n <= idos_pkg::WCW'(idos_pkg::WorkSlots)), "work list overflow")
    `IDOS_ASSERT(a_take_idle, i_clk, i_rst_n, (o_job_take |=> (r_state == S_DISPATCH)), "job taken outside idle")
endmodule

[design/isometric_depth_order_sorter.sv]
// top level of the isometric depth order sorter
// usage:
//   input channel: drive i_word and raise push; a word is taken on an edge
//   where full is low. commands: insert static, insert dynamic, remove
//   static, remove dynamic, emit order. unknown codes are dropped silently.
//   result channel: o_word is valid while empty is low, taken with pop.
//   inserts and removes give one status word; order gives one word per
//   listed entry with ranks from 1 and last on the final one, or one status.
//   a two-deep job queue sits in front of the list engine. an insert static
//   that appends runs load and copy back; one that splits runs load, a split
//   walk over the n stored statics, a merge of h later entries and copy back.
//   removes walk the list once; order loads the statics and then runs at
//   most one split walk of up to 47 entries per dynamic, then emits one word
//   a cycle while the receiver keeps popping.
//   the list engine handles one command at a time.
//   reset: both lists empty, the static list marked dirty, queue cleared.
//   a stalled receiver holds the single output register, and the engine
//   waits; the front queue keeps taking words until it fills.
module isometric_depth_order_sorter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  idos_pkg::t_in_word    i_word,
    input  logic                  push,
    output logic                  full,
    output idos_pkg::t_out_word   o_word,
    output logic                  empty,
    input  logic                  pop
);
    idos_pkg::t_job w_job;
    logic           w_job_valid;
    logic           w_job_take;

    idos_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_word),
        .i_push      (push),
        .o_full      (full),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_take  (w_job_take)
    );

    idos_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_take  (w_job_take),
        .o_word      (o_word),
        .o_empty     (empty),
        .i_pop       (pop)
    );
endmodule
